// ----- rtl/fbik_pkg.sv -----
// Shared register indexes, constants and functions for the five-bar arm solver.
// Holds the Q30 arctangent table and the angle output rounding.
// No dependencies.
package fbik_pkg;

  localparam int COORD_BITS      = 8;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 28;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 8;

  localparam logic [7:0] COORD_MASK = 8'((1 << COORD_BITS) - 1);

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

  localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_LEFT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_LEFT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_SPAN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOWER_RIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_RIGHT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_Y      = 3'd6;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] to_angle(input logic [34:0] q30);
    logic [34:0] rnd;
    logic [34:0] shr;
    rnd = q30 + (35'd1 << (29 - ANGLE_FRAC_BITS));
    shr = rnd >> (30 - ANGLE_FRAC_BITS);
    return (shr > 35'd65535) ? 16'hFFFF : shr[15:0];
  endfunction

endpackage

// ----- rtl/five_bar_inverse_kinematics_core.sv -----
// Top level of the five-bar arm solver: servo angles and move delay per target.
// Depends on fbik_pkg; one shared multiplier, sqrt and CORDIC step under a sequencer.
//
//  channel  dir  handshake              word
//  in       in   in_valid_i/in_ready_o  target_x_i, target_y_i
//  out      out  out_valid_o/out_ready_i left_angle_o, right_angle_o, move_delay_o,
//                                       unreachable_o
//  cfg      in   cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// Each word runs 19 products on the one multiplier, then per angle term up to 28 scaling
// steps, 32 sqrt steps and 28 CORDIC steps (a clamped or degenerate term skips these),
// then a 32-step sqrt for the move delay.
// in_ready_o is high only while idle; a finished word waits in the output register
// and the next target is taken meanwhile. Reset restores the register defaults and
// clears the previous target.
module five_bar_inverse_kinematics_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  target_x_i,
  input  logic [7:0]  target_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] left_angle_o,
  output logic [15:0] right_angle_o,
  output logic [8:0]  move_delay_o,
  output logic        unreachable_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_TERM  = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  logic [7:0] upper_left_q, lower_left_q, span_q, lower_right_q, upper_right_q;
  logic [7:0] center_x_q, base_y_q;
  logic [7:0] prev_x_q, prev_y_q;
  logic [7:0] x_q, y_q;
  logic signed [8:0] ex_q, ey_q;

  logic [4:0]  op_q;
  logic [17:0] dy2_q, m2_q, l2_q, r2_q, ex2_q, ey2_q;
  logic [15:0] pl2_q, dl2_q, pr2_q, dr2_q, sp2_q;
  logic [39:0] den_q [4];
  logic [39:0] n2_q [4];

  logic [2:0]  term_q;
  logic        neg_q;
  logic [4:0]  s_q;
  logic [61:0] work_q;
  logic [63:0] sq_v_q, sq_r_q;
  logic [4:0]  cnt_q;
  logic [30:0] magsh_q;
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [34:0] left_acc_q, right_acc_q;
  logic        flag_q;

  logic [15:0] left_q, right_q;
  logic        unreach_q, out_valid_q;

  logic in_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  logic signed [9:0]  dy, dxm;
  logic signed [10:0] dxl, dxr;
  logic [6:0]  half;
  logic [18:0] lll, llr, llm;
  assign half = span_q[7:1];
  assign dy   = $signed({2'b00, y_q}) - $signed({2'b00, base_y_q});
  assign dxm  = $signed({2'b00, x_q}) - $signed({2'b00, center_x_q});
  assign dxl  = 11'(dxm) + $signed({4'b0000, half});
  assign dxr  = 11'(dxm) - $signed({4'b0000, half});
  assign lll  = 19'(l2_q) + 19'(dy2_q);
  assign llr  = 19'(r2_q) + 19'(dy2_q);
  assign llm  = 19'(m2_q) + 19'(dy2_q);

  logic signed [20:0] num_t [4];
  assign num_t[0] = $signed({5'd0, pl2_q}) + $signed({2'b00, lll}) - $signed({5'd0, dl2_q});
  assign num_t[1] = $signed({2'b00, lll}) + $signed({7'd0, sp2_q[15:2]})
                  - $signed({2'b00, llm});
  assign num_t[2] = $signed({5'd0, pr2_q}) + $signed({2'b00, llr}) - $signed({5'd0, dr2_q});
  assign num_t[3] = $signed({2'b00, llr}) + $signed({7'd0, sp2_q[15:2]})
                  - $signed({2'b00, llm});

  logic [1:0]         tix;
  logic signed [20:0] num_cur;
  logic [19:0]        mag_cur;
  logic [1:0]         mop;
  assign tix     = term_q[1:0];
  assign num_cur = num_t[tix];
  assign mag_cur = num_cur[20] ? 20'(-num_cur) : num_cur[19:0];
  assign mop     = 2'(op_q - 5'd15);

  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] mul_p;
  logic signed [20:0] num_m;
  assign num_m = num_t[mop];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      5'd0:  begin mul_a = 21'(dy);  mul_b = 21'(dy);  end
      5'd1:  begin mul_a = 21'(dxm); mul_b = 21'(dxm); end
      5'd2:  begin mul_a = 21'(dxl); mul_b = 21'(dxl); end
      5'd3:  begin mul_a = 21'(dxr); mul_b = 21'(dxr); end
      5'd4:  begin mul_a = 21'(ex_q); mul_b = 21'(ex_q); end
      5'd5:  begin mul_a = 21'(ey_q); mul_b = 21'(ey_q); end
      5'd6:  begin mul_a = $signed({13'd0, lower_left_q});  mul_b = mul_a; end
      5'd7:  begin mul_a = $signed({13'd0, upper_left_q});  mul_b = mul_a; end
      5'd8:  begin mul_a = $signed({13'd0, lower_right_q}); mul_b = mul_a; end
      5'd9:  begin mul_a = $signed({13'd0, upper_right_q}); mul_b = mul_a; end
      5'd10: begin mul_a = $signed({13'd0, span_q});        mul_b = mul_a; end
      5'd11: begin mul_a = $signed({3'd0, pl2_q, 2'b00}); mul_b = $signed({2'b00, lll}); end
      5'd12: begin mul_a = $signed({5'd0, sp2_q});        mul_b = $signed({2'b00, lll}); end
      5'd13: begin mul_a = $signed({3'd0, pr2_q, 2'b00}); mul_b = $signed({2'b00, llr}); end
      5'd14: begin mul_a = $signed({5'd0, sp2_q});        mul_b = $signed({2'b00, llr}); end
      default: begin mul_a = num_m; mul_b = num_m; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic [63:0] sq_bit, sq_t;
  assign sq_bit = 64'd1 << (6'd62 - {cnt_q, 1'b0});
  assign sq_t   = sq_r_q + sq_bit;

  logic signed [35:0] cxs, cys, atan_v, z_clamp;
  assign cxs     = cx_q >>> cnt_q;
  assign cys     = cy_q >>> cnt_q;
  assign atan_v  = $signed({6'd0, fbik_pkg::atan_q30(cnt_q)});
  assign z_clamp = cz_q[35] ? 36'sd0 : ((cz_q > fbik_pkg::PI_Q30) ? fbik_pkg::PI_Q30 : cz_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MUL;
      S_MUL:   if (op_q == 5'd18) state_d = S_TERM;
      S_TERM:  begin
        if (term_q == 3'd4) state_d = S_SQRT;
        else if (den_q[tix] == 40'd0 || n2_q[tix] > den_q[tix]) state_d = S_ACC;
        else state_d = S_NORM;
      end
      S_NORM:  if (s_q == 5'd28 || work_q[61:60] != 2'b00) state_d = S_SQRT;
      S_SQRT:  if (cnt_q == 5'd31) state_d = (term_q == 3'd4) ? S_DONE : S_CINIT;
      S_CINIT: state_d = S_CORD;
      S_CORD:  if (cnt_q == 5'(fbik_pkg::CORDIC_STEPS - 1)) state_d = S_ACC;
      S_ACC:   state_d = S_TERM;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      upper_left_q  <= 8'd50;
      lower_left_q  <= 8'd50;
      span_q        <= 8'd50;
      lower_right_q <= 8'd50;
      upper_right_q <= 8'd50;
      center_x_q    <= 8'd15;
      base_y_q      <= 8'd100;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          fbik_pkg::CFG_UPPER_LEFT:  upper_left_q  <= cfg_wdata_i;
          fbik_pkg::CFG_LOWER_LEFT:  lower_left_q  <= cfg_wdata_i;
          fbik_pkg::CFG_BASE_SPAN:   span_q        <= cfg_wdata_i;
          fbik_pkg::CFG_LOWER_RIGHT: lower_right_q <= cfg_wdata_i;
          fbik_pkg::CFG_UPPER_RIGHT: upper_right_q <= cfg_wdata_i;
          fbik_pkg::CFG_CENTER_X:    center_x_q    <= cfg_wdata_i;
          fbik_pkg::CFG_BASE_Y:      base_y_q      <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_x_q <= target_x_i & fbik_pkg::COORD_MASK;
        prev_y_q <= target_y_i & fbik_pkg::COORD_MASK;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_q         <= target_x_i & fbik_pkg::COORD_MASK;
          y_q         <= target_y_i & fbik_pkg::COORD_MASK;
          ex_q        <= $signed({1'b0, target_x_i & fbik_pkg::COORD_MASK})
                       - $signed({1'b0, prev_x_q});
          ey_q        <= $signed({1'b0, target_y_i & fbik_pkg::COORD_MASK})
                       - $signed({1'b0, prev_y_q});
          op_q        <= '0;
          term_q      <= '0;
          flag_q      <= 1'b0;
          left_acc_q  <= '0;
          right_acc_q <= '0;
        end
      end
      S_MUL: begin
        op_q <= op_q + 5'd1;
        case (op_q)
          5'd0:  dy2_q <= mul_p[17:0];
          5'd1:  m2_q  <= mul_p[17:0];
          5'd2:  l2_q  <= mul_p[17:0];
          5'd3:  r2_q  <= mul_p[17:0];
          5'd4:  ex2_q <= mul_p[17:0];
          5'd5:  ey2_q <= mul_p[17:0];
          5'd6:  pl2_q <= mul_p[15:0];
          5'd7:  dl2_q <= mul_p[15:0];
          5'd8:  pr2_q <= mul_p[15:0];
          5'd9:  dr2_q <= mul_p[15:0];
          5'd10: sp2_q <= mul_p[15:0];
          5'd11: den_q[0] <= mul_p[39:0];
          5'd12: den_q[1] <= mul_p[39:0];
          5'd13: den_q[2] <= mul_p[39:0];
          5'd14: den_q[3] <= mul_p[39:0];
          default: n2_q[mop] <= mul_p[39:0];
        endcase
      end
      S_TERM: begin
        cnt_q <= '0;
        sq_r_q <= '0;
        if (term_q == 3'd4) begin
          sq_v_q <= 64'(ex2_q) + 64'(ey2_q);
        end else if (den_q[tix] == 40'd0) begin
          flag_q <= 1'b1;
          cz_q   <= '0;
        end else if (n2_q[tix] > den_q[tix]) begin
          flag_q <= 1'b1;
          cz_q   <= num_cur[20] ? fbik_pkg::PI_Q30 : 36'sd0;
        end else begin
          neg_q   <= num_cur[20];
          s_q     <= '0;
          work_q  <= 62'(den_q[tix]);
          sq_v_q  <= 64'(den_q[tix] - n2_q[tix]);
          magsh_q <= 31'(mag_cur);
        end
      end
      S_NORM: begin
        if (s_q != 5'd28 && work_q[61:60] == 2'b00) begin
          s_q     <= s_q + 5'd1;
          work_q  <= work_q << 2;
          sq_v_q  <= sq_v_q << 2;
          magsh_q <= magsh_q << 1;
        end
      end
      S_SQRT: begin
        cnt_q <= cnt_q + 5'd1;
        if (sq_v_q >= sq_t) begin
          sq_v_q <= sq_v_q - sq_t;
          sq_r_q <= (sq_r_q >> 1) + sq_bit;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        if (cnt_q == 5'd31 && term_q == 3'd4) begin
          left_q    <= fbik_pkg::to_angle(left_acc_q);
          right_q   <= fbik_pkg::to_angle(right_acc_q);
          unreach_q <= flag_q;
        end
      end
      S_CINIT: begin
        cnt_q <= '0;
        if (neg_q) begin
          cx_q <= $signed({4'd0, sq_r_q[31:0]});
          cy_q <= $signed({5'd0, magsh_q});
          cz_q <= fbik_pkg::HALF_PI_Q30;
        end else begin
          cx_q <= $signed({5'd0, magsh_q});
          cy_q <= $signed({4'd0, sq_r_q[31:0]});
          cz_q <= '0;
        end
      end
      S_CORD: begin
        cnt_q <= cnt_q + 5'd1;
        if (!cy_q[35]) begin
          cx_q <= cx_q + cys;
          cy_q <= cy_q - cxs;
          cz_q <= cz_q + atan_v;
        end else begin
          cx_q <= cx_q - cys;
          cy_q <= cy_q + cxs;
          cz_q <= cz_q - atan_v;
        end
      end
      S_ACC: begin
        term_q <= term_q + 3'd1;
        if (!term_q[1]) left_acc_q <= left_acc_q + 35'(z_clamp);
        else right_acc_q <= right_acc_q + 35'(z_clamp);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      left_angle_o  <= left_q;
      right_angle_o <= right_q;
      unreachable_o <= unreach_q;
      move_delay_o  <= (sq_r_q > 64'd511) ? 9'd511 : sq_r_q[8:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/fbik_checker.sv -----
// Port-level checks for the five-bar arm solver, attached by bind.
// Depends on the top level's ports only.
module fbik_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] left_angle_o,
  input logic [8:0]  move_delay_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted word");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_angle_o))
    else $error("stalled result word changed");

  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> move_delay_o <= 9'd361)
    else $error("move delay beyond grid diagonal");

endmodule

bind five_bar_inverse_kinematics_core fbik_checker u_fbik_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .left_angle_o (left_angle_o),
  .move_delay_o (move_delay_o)
);

// ----- verif/five_bar_inverse_kinematics_core_test.sv -----
// Testbench for five_bar_inverse_kinematics_core: drives pen targets and link
// settings, and checks servo angles, move delay and the reach flag against a local model.
// Depends on fbik_pkg and the core RTL.
`timescale 1ns / 100ps

module five_bar_inverse_kinematics_core_test;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [15:0] left_angle;
    logic [15:0] right_angle;
    logic [8:0]  move_delay;
    logic        unreachable;
  } arm_word_t;

  class arm_scoreboard;
    logic [7:0] link_reg[7];
    logic [7:0] prev_x, prev_y;
    arm_word_t  pending_words[$];
    int         errors;
    int         words_checked;
    int         flagged;
    longint     atan_tab[28];

    function new();
      atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                   131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                   127, 63, 31, 15, 7};
      link_reg = '{8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd15, 8'd100};
      prev_x = 0;
      prev_y = 0;
      errors = 0;
      words_checked = 0;
      flagged = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
      if (idx < 3'd7) link_reg[idx] = val;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint cos_angle(longint num, longint unsigned den2, inout bit flag);
      longint unsigned mag, n2, ym;
      int s;
      longint x, y, z, nx, t;
      z = 0;
      s = 0;
      if (den2 == 0) begin
        flag = 1;
        return 0;
      end
      mag = (num < 0) ? longint'(-num) : longint'(num);
      n2 = mag * mag;
      if (n2 > den2) begin
        flag = 1;
        return (num < 0) ? longint'(fbik_pkg::PI_Q30) : 0;
      end
      while (s < 28 && den2 < ((64'd1 << 62) >> (2 * s + 2))) s++;
      ym = floor_sqrt((den2 - n2) << (2 * s));
      x = longint'(mag << s);
      if (num < 0) x = -x;
      y = longint'(ym);
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = longint'(fbik_pkg::HALF_PI_Q30);
      end
      for (int i = 0; i < 28; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_tab[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_tab[i];
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > longint'(fbik_pkg::PI_Q30)) z = longint'(fbik_pkg::PI_Q30);
      return z;
    endfunction

    function logic [15:0] round_angle(longint q);
      longint unsigned r;
      r = (longint'(q) + (64'd1 << (29 - fbik_pkg::ANGLE_FRAC_BITS)))
          >> (30 - fbik_pkg::ANGLE_FRAC_BITS);
      return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function void note_target(logic [7:0] tx, logic [7:0] ty);
      longint x, y, span, half, hsq, span2, dy, dxm, dxl, dxr, llm, lll, llr;
      longint pl, dl, pr, dr, ex, ey, left, right;
      longint unsigned travel;
      bit flag;
      arm_word_t w;
      flag = 0;
      x = tx;
      y = ty;
      span = link_reg[fbik_pkg::CFG_BASE_SPAN];
      half = span >> 1;
      hsq = (span * span) >> 2;
      span2 = span * span;
      dy = y - longint'(link_reg[fbik_pkg::CFG_BASE_Y]);
      dxm = x - longint'(link_reg[fbik_pkg::CFG_CENTER_X]);
      dxl = dxm + half;
      dxr = dxm - half;
      llm = dxm * dxm + dy * dy;
      lll = dxl * dxl + dy * dy;
      llr = dxr * dxr + dy * dy;
      pl = link_reg[fbik_pkg::CFG_LOWER_LEFT];
      dl = link_reg[fbik_pkg::CFG_UPPER_LEFT];
      pr = link_reg[fbik_pkg::CFG_LOWER_RIGHT];
      dr = link_reg[fbik_pkg::CFG_UPPER_RIGHT];
      left = cos_angle(pl * pl + lll - dl * dl, 4 * pl * pl * lll, flag)
           + cos_angle(lll + hsq - llm, span2 * lll, flag);
      right = cos_angle(pr * pr + llr - dr * dr, 4 * pr * pr * llr, flag)
            + cos_angle(llr + hsq - llm, span2 * llr, flag);
      ex = x - longint'(prev_x);
      ey = y - longint'(prev_y);
      travel = floor_sqrt(ex * ex + ey * ey);
      if (travel > 511) travel = 511;
      prev_x = tx;
      prev_y = ty;
      w.left_angle = round_angle(left);
      w.right_angle = round_angle(right);
      w.move_delay = travel[8:0];
      w.unreachable = flag;
      if (flag) flagged++;
      pending_words.push_back(w);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("word %0d: %s got %0d want %0d", words_checked, what, got, want);
      errors++;
    endtask

    task check_word(arm_word_t got);
      arm_word_t want;
      if (pending_words.size() == 0) begin
        report("unexpected word, left", got.left_angle, 16'd0);
      end else begin
        want = pending_words.pop_front();
        if (got.left_angle !== want.left_angle)
          report("left_angle", got.left_angle, want.left_angle);
        if (got.right_angle !== want.right_angle)
          report("right_angle", got.right_angle, want.right_angle);
        if (got.move_delay !== want.move_delay)
          report("move_delay", 16'(got.move_delay), 16'(want.move_delay));
        if (got.unreachable !== want.unreachable)
          report("unreachable", 16'(got.unreachable), 16'(want.unreachable));
      end
      words_checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  target_x_i;
  logic [7:0]  target_y_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] left_angle_o;
  logic [15:0] right_angle_o;
  logic [8:0]  move_delay_o;
  logic        unreachable_o;

  arm_scoreboard sb;
  bit quiet;
  bit hold_req;
  int ready_wait;

  five_bar_inverse_kinematics_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .target_x_i(target_x_i), .target_y_i(target_y_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .left_angle_o(left_angle_o), .right_angle_o(right_angle_o),
    .move_delay_o(move_delay_o), .unreachable_o(unreachable_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("five_bar_inverse_kinematics_core: mismatch");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    ready_wait = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (1500) @(negedge clk_i);
      end
      if (ready_wait > 0) begin
        out_ready_i <= 1'b0;
        ready_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word('{left_angle_o, right_angle_o, move_delay_o, unreachable_o});
      ready_wait = quiet ? 0 : $urandom_range(0, 8);
    end
  end

  task send_target(logic [7:0] tx, logic [7:0] ty);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_x_i <= tx;
    target_y_i <= ty;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_target(tx, ty);
    @(negedge clk_i);
  endtask

  task drain;
    in_valid_i <= 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task write_all(logic [7:0] ul, logic [7:0] ll, logic [7:0] sp, logic [7:0] lr,
                 logic [7:0] ur, logic [7:0] cx, logic [7:0] by);
    write_reg(fbik_pkg::CFG_UPPER_LEFT, ul);
    write_reg(fbik_pkg::CFG_LOWER_LEFT, ll);
    write_reg(fbik_pkg::CFG_BASE_SPAN, sp);
    write_reg(fbik_pkg::CFG_LOWER_RIGHT, lr);
    write_reg(fbik_pkg::CFG_UPPER_RIGHT, ur);
    write_reg(fbik_pkg::CFG_CENTER_X, cx);
    write_reg(fbik_pkg::CFG_BASE_Y, by);
  endtask

  function logic [7:0] near(logic [7:0] c, int spread);
    int v;
    v = int'(c) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task random_targets(int n);
    int spread;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        send_target(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        spread = sb.link_reg[fbik_pkg::CFG_LOWER_LEFT]
               + sb.link_reg[fbik_pkg::CFG_UPPER_LEFT] + 4;
        if (spread > 255) spread = 255;
        send_target(near(sb.link_reg[fbik_pkg::CFG_CENTER_X], spread),
                    near(sb.link_reg[fbik_pkg::CFG_BASE_Y], spread));
      end
    end
  endtask

  initial begin
    sb = new();
    quiet = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    target_x_i = '0;
    target_y_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: corners, axis midpoint, long moves, reset settings
    send_target(8'd0, 8'd0);
    send_target(8'd255, 8'd255);
    send_target(8'd0, 8'd255);
    send_target(8'd255, 8'd0);
    send_target(8'd15, 8'd100);
    send_target(8'd15, 8'd60);
    send_target(8'd40, 8'd100);
    send_target(8'd15, 8'd30);
    drain();
    // target on each servo axis, and an ignored register index
    write_all(8'd60, 8'd40, 8'd50, 8'd40, 8'd60, 8'd100, 8'd100);
    write_reg(CFG_UNUSED, 8'hAA);
    send_target(8'd75, 8'd100);
    send_target(8'd125, 8'd100);
    send_target(8'd100, 8'd40);
    send_target(8'd100, 8'd160);
    send_target(8'd170, 8'd100);
    drain();
    // zero link and zero span
    write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128);
    send_target(8'd128, 8'd128);
    send_target(8'd100, 8'd60);
    drain();
    write_all(8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd0, 8'd0);
    send_target(8'd0, 8'd0);
    send_target(8'd127, 8'd0);
    send_target(8'd255, 8'd255);
    drain();
    write_all(8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd255, 8'd255);
    send_target(8'd255, 8'd255);
    send_target(8'd254, 8'd255);
    send_target(8'd0, 8'd0);
    drain();

    write_all(8'd50, 8'd50, 8'd50, 8'd50, 8'd50, 8'd15, 8'd100);
    random_targets(120);
    drain();
    write_all(8'd70, 8'd45, 8'd40, 8'd45, 8'd70, 8'd128, 8'd60);
    hold_req = 1;
    random_targets(120);
    drain();
    write_all(8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd0, 8'd0);
    random_targets(100);
    drain();
    write_all(8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd255, 8'd255);
    random_targets(100);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_all(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'(2 * $urandom_range(1, 127)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      random_targets(100);
      drain();
    end

    repeat (50) @(negedge clk_i);
    $display("covered %0d targets over 14 link settings, %0d flagged unreachable",
             sb.words_checked, sb.flagged);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("five_bar_inverse_kinematics_core: match");
    end else begin
      $display("five_bar_inverse_kinematics_core: mismatch");
    end
    $finish;
  end

endmodule
